// ----- rtl/core/tvde_pkg.sv -----
package tvde_pkg;

    localparam int MEM_ADDR_BITS_DEF = 14;
    localparam int DOTS_PER_LINE     = 341;
    localparam int LINES_PER_FRAME   = 262;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [15:0] PALETTE_BASE = 16'h3F00;
    localparam logic [15:0] ATTR_OFFSET  = 16'h03C0;
    localparam logic [15:0] NAME_BASE    = 16'h2000;

    // column formula (dot/8 + 2) mod 42 for dots 0..340
    function automatic logic [5:0] tile_col(input logic [8:0] dot);
        logic [6:0] c;
        begin
            c = {1'b0, dot[8:3]} + 7'd2;
            if (c >= 7'd42)
            begin
                c = c - 7'd42;
            end
            tile_col = c[5:0];
        end
    endfunction

    // result of one item
    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] pixel_color;
        logic [8:0] pixel_x;
        logic [8:0] pixel_y;
        logic       visible;
        logic       nmi_pulse;
        logic       frame_done;
        logic       rendering_on;
    } result_t;

endpackage

// ----- rtl/core/tvde_vram.sv -----
module tvde_vram
    import tvde_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [MEM_ADDR_BITS-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    localparam int DEPTH = 1 << MEM_ADDR_BITS;

    logic [7:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/core/tile_video_dot_engine_top.sv -----
// Tile video dot engine.
// Two memory phases per item; the second loads the output register, waiting while it holds an untaken result.
// Items do not overlap: a new one is accepted only in idle or at the end of phase 2 of the last one,
// set by the single video memory port (fetch, then palette).
// Reset: asynchronous active low; after reset a clearing pass writes zero to all 2^MEM_ADDR_BITS
// video memory addresses, during which no item is accepted.
module tile_video_dot_engine_top
    import tvde_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [2:0] reg_index,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic [7:0] pixel_color,
    output logic [8:0] pixel_x,
    output logic [8:0] pixel_y,
    output logic       visible,
    output logic       nmi_pulse,
    output logic       frame_done,
    output logic       rendering_on
);

    localparam int AW = MEM_ADDR_BITS;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_PH1   = 4'b0100,
        ST_PH2   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [AW:0] clr_reg, clr_next;

    // architectural state
    logic [8:0]  dot_reg, dot_next, line_reg, line_next;
    logic [15:0] ptr_reg, ptr_next;
    logic [7:0]  rbuf_reg, rbuf_next;
    logic        tog_reg, tog_next;
    logic [7:0]  ctrl_reg, ctrl_next, mask_reg, mask_next;
    logic        vbl_reg, vbl_next, nmi_reg, nmi_next;
    logic [5:0]  tcol_reg, tcol_next, trow_reg, trow_next;
    logic [15:0] shl_reg, shl_next, shh_reg, shh_next;
    logic [7:0]  ftile_reg, ftile_next, fattr_reg, fattr_next;
    logic [7:0]  fpl_reg, fpl_next, fph_reg, fph_next;
    logic [7:0]  lpix_reg, lpix_next;
    logic [8:0]  lx_reg, lx_next, ly_reg, ly_next;
    logic        vis_reg, vis_next;

    // item held across the two phases
    logic [1:0] func_reg;
    logic [2:0] ridx_reg;
    logic       rdl_reg;     // tick on a read line
    logic [1:0] fsel_reg;    // which fetched byte memory returns: 0 tile 1 attr 2 low 3 high
    logic       fen_reg;
    logic [7:0] rd_reg;

    // output register
    logic    ovalid_reg;
    result_t ores_reg;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;

    tvde_vram #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_vram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    logic accept, out_free;
    assign out_free = !ovalid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_PH2) && out_free);
    assign accept   = in_valid && in_ready;

    // decode of accepted tick
    logic        t_normal, t_pre, t_visl, t_rdl, t_shift, t_fetch;
    logic [2:0]  t_phase;
    logic [8:0]  row_line;
    logic [15:0] tbase, pbase, f_addr;
    logic [5:0]  n_tcol, n_trow;
    logic [15:0] sl_sh, sh_sh;

    always_comb
    begin
        t_normal = dot_reg <= 9'd256;
        t_pre    = (dot_reg >= 9'd321) && (dot_reg <= 9'd336);
        t_visl   = line_reg <= 9'd239;
        t_rdl    = t_visl || (line_reg == 9'd261);
        t_shift  = t_rdl && (t_normal || t_pre);
        t_phase  = 3'(dot_reg - 9'd1);
        t_fetch  = t_shift && (dot_reg != 9'd0) && !t_phase[0];
        row_line = line_reg + {8'd0, t_pre};
        tbase    = NAME_BASE + {4'd0, ctrl_reg[1:0], 10'd0};
        pbase    = ctrl_reg[4] ? 16'h1000 : 16'h0000;
        n_tcol   = tcol_reg;
        n_trow   = trow_reg;
        if (t_fetch && (t_phase == 3'd0))
        begin
            n_tcol = tile_col(dot_reg);
            n_trow = row_line[8:3];
        end
        unique case (t_phase[2:1])
            2'd0:    f_addr = tbase + {10'd0, n_tcol} + {5'd0, n_trow, 5'd0};
            2'd1:    f_addr = tbase + ATTR_OFFSET + {12'd0, n_tcol[5:2]}
                              + {9'd0, n_trow[5:2], 3'd0};
            2'd2:    f_addr = pbase + {4'd0, ftile_reg, 4'd0} + {13'd0, row_line[2:0]};
            default: f_addr = pbase + {4'd0, ftile_reg, 4'd0} + {13'd0, row_line[2:0]} + 16'd8;
        endcase
        // pixel comes from state as it stands after this tick's fetch phase
        sl_sh = shl_reg;
        sh_sh = shh_reg;
        if (t_shift)
        begin
            sl_sh = {shl_reg[14:0], 1'b0};
            sh_sh = {shh_reg[14:0], 1'b0};
            if (t_fetch && (t_phase == 3'd0))
            begin
                sl_sh = {sl_sh[15:8], fpl_reg};
                sh_sh = {sh_sh[15:8], fph_reg};
            end
        end
    end

    // palette address needs the attribute, which may be fetched this item
    logic [7:0] attr_now;
    always_comb
    begin
        attr_now = ((state_reg == ST_PH1) && fen_reg && (fsel_reg == 2'd1)) ? mem_rdata
                                                                            : fattr_reg;
    end

    logic [1:0] pal_ph;
    logic [15:0] pal_addr;
    always_comb
    begin
        case ({trow_reg[1], tcol_reg[1]})
            2'b00:   pal_ph = attr_now[1:0];
            2'b01:   pal_ph = attr_now[3:2];
            2'b10:   pal_ph = attr_now[5:4];
            default: pal_ph = attr_now[7:6];
        endcase
        pal_addr = PALETTE_BASE + {12'd0, pal_ph, 2'b00} + {14'd0, shh_reg[15], shl_reg[15]};
    end

    logic [15:0] step;
    assign step = ctrl_reg[2] ? 16'd32 : 16'd1;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        dot_next = dot_reg; line_next = line_reg; ptr_next = ptr_reg;
        rbuf_next = rbuf_reg; tog_next = tog_reg; ctrl_next = ctrl_reg;
        mask_next = mask_reg; vbl_next = vbl_reg; nmi_next = nmi_reg;
        tcol_next = tcol_reg; trow_next = trow_reg; shl_next = shl_reg;
        shh_next = shh_reg; ftile_next = ftile_reg; fattr_next = fattr_reg;
        fpl_next = fpl_reg; fph_next = fph_reg; lpix_next = lpix_reg;
        lx_next = lx_reg; ly_next = ly_reg; vis_next = vis_reg;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = 8'd0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg[AW-1:0] == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PH1:
            begin
                // take memory result of phase 1
                if (func_reg == FUNC_TICK)
                begin
                    if (fen_reg)
                    begin
                        case (fsel_reg)
                            2'd0:    ftile_next = mem_rdata;
                            2'd1:    fattr_next = mem_rdata;
                            2'd2:    fpl_next   = mem_rdata;
                            default: fph_next   = mem_rdata;
                        endcase
                    end
                    if (rdl_reg)
                    begin
                        mem_addr = pal_addr[AW-1:0];
                    end
                end
                else if ((func_reg == FUNC_READ) && (ridx_reg == REG_DATA))
                begin
                    rbuf_next = mem_rdata;
                    ptr_next  = ptr_reg + step;
                end
                state_next = ST_PH2;
            end
            ST_PH2:
            begin
                // hold the palette read while the result waits
                if ((func_reg == FUNC_TICK) && rdl_reg)
                begin
                    lpix_next = mem_rdata;
                    mem_addr  = pal_addr[AW-1:0];
                end
            end
            default:
            begin
            end
        endcase

        // accept a new item in idle or at the end of phase 2
        if (accept)
        begin
            state_next = ST_PH1;
            nmi_next   = 1'b0;
            unique case (func_t'(func))
                FUNC_TICK:
                begin
                    if (t_shift)
                    begin
                        shl_next  = sl_sh;
                        shh_next  = sh_sh;
                        tcol_next = n_tcol;
                        trow_next = n_trow;
                    end
                    if (t_fetch)
                    begin
                        mem_addr = f_addr[AW-1:0];
                    end
                    if (t_rdl)
                    begin
                        lx_next = dot_reg;
                        ly_next = line_reg;
                    end
                    vis_next = t_normal && t_visl;
                    if ((line_reg == 9'd241) && (dot_reg == 9'd1))
                    begin
                        vbl_next = 1'b1;
                        if (ctrl_reg[7])
                        begin
                            nmi_next = 1'b1;
                        end
                    end
                    else if ((line_reg == 9'd261) && (dot_reg == 9'd1))
                    begin
                        vbl_next = 1'b0;
                    end
                    if (dot_reg == 9'(DOTS_PER_LINE - 1))
                    begin
                        dot_next  = 9'd0;
                        line_next = (line_reg == 9'(LINES_PER_FRAME - 1)) ? 9'd0
                                                                           : line_reg + 9'd1;
                    end
                    else
                    begin
                        dot_next = dot_reg + 9'd1;
                    end
                end
                FUNC_READ:
                begin
                    if (reg_index == REG_STATUS)
                    begin
                        vbl_next = 1'b0;
                        tog_next = 1'b0;
                    end
                    else if (reg_index == REG_DATA)
                    begin
                        mem_addr = ptr_reg[AW-1:0];
                    end
                end
                FUNC_WRITE:
                begin
                    case (reg_index)
                        REG_CTRL: ctrl_next = write_data;
                        REG_MASK: mask_next = write_data;
                        REG_ADDR:
                        begin
                            if (tog_reg)
                            begin
                                ptr_next = {ptr_reg[15:8], write_data};
                            end
                            else
                            begin
                                ptr_next = {write_data, ptr_reg[7:0]};
                            end
                            tog_next = !tog_reg;
                        end
                        REG_DATA:
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = ptr_reg[AW-1:0];
                            mem_wdata = write_data;
                            ptr_next  = ptr_reg + step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == ST_PH2 && out_free)
        begin
            state_next = ST_IDLE;
        end
    end

    // hold the item and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            dot_reg <= '0; line_reg <= '0; ptr_reg <= '0; rbuf_reg <= '0;
            tog_reg <= 1'b0; ctrl_reg <= '0; mask_reg <= '0; vbl_reg <= 1'b0;
            nmi_reg <= 1'b0; tcol_reg <= '0; trow_reg <= '0; shl_reg <= '0;
            shh_reg <= '0; ftile_reg <= '0; fattr_reg <= '0; fpl_reg <= '0;
            fph_reg <= '0; lpix_reg <= '0; lx_reg <= '0; ly_reg <= '0;
            vis_reg <= 1'b0;
            func_reg <= FUNC_NONE; ridx_reg <= '0; rdl_reg <= 1'b0;
            fsel_reg <= '0; fen_reg <= 1'b0; rd_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            dot_reg <= dot_next; line_reg <= line_next; ptr_reg <= ptr_next;
            rbuf_reg <= rbuf_next; tog_reg <= tog_next; ctrl_reg <= ctrl_next;
            mask_reg <= mask_next; vbl_reg <= vbl_next; nmi_reg <= nmi_next;
            tcol_reg <= tcol_next; trow_reg <= trow_next; shl_reg <= shl_next;
            shh_reg <= shh_next; ftile_reg <= ftile_next; fattr_reg <= fattr_next;
            fpl_reg <= fpl_next; fph_reg <= fph_next; lpix_reg <= lpix_next;
            lx_reg <= lx_next; ly_reg <= ly_next; vis_reg <= vis_next;
            if (accept)
            begin
                func_reg <= func;
                ridx_reg <= reg_index;
                rdl_reg  <= t_rdl;
                fsel_reg <= t_phase[2:1];
                fen_reg  <= (func == FUNC_TICK) && t_fetch;
                rd_reg   <= ((func == FUNC_READ) && (reg_index == REG_STATUS))
                            ? {vbl_reg, 7'd0} : 8'd0;
            end
            // present the result at the end of phase 2
            if (state_reg == ST_PH2 && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // buffer value before refill, captured at accept
    logic [7:0] rd_hold_reg;

    // payload of the output register
    logic [7:0] rd_fin;
    always_comb
    begin
        rd_fin = rd_reg;
        if ((func_reg == FUNC_READ) && (ridx_reg == REG_DATA))
        begin
            rd_fin = (ptr_reg - step >= PALETTE_BASE) ? rbuf_reg : rd_hold_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_hold_reg <= rbuf_reg;
        end
        if (state_reg == ST_PH2 && out_free)
        begin
            ores_reg.read_data    <= rd_fin;
            ores_reg.pixel_color  <= ((func_reg == FUNC_TICK) && rdl_reg) ? mem_rdata : lpix_reg;
            ores_reg.pixel_x      <= lx_reg;
            ores_reg.pixel_y      <= ly_reg;
            ores_reg.visible      <= vis_reg;
            ores_reg.nmi_pulse    <= nmi_reg;
            ores_reg.frame_done   <= (line_reg == 9'd240) && (dot_reg == 9'd0);
            ores_reg.rendering_on <= mask_reg[3] | mask_reg[4];
        end
    end

    assign out_valid    = ovalid_reg;
    assign read_data    = ores_reg.read_data;
    assign pixel_color  = ores_reg.pixel_color;
    assign pixel_x      = ores_reg.pixel_x;
    assign pixel_y      = ores_reg.pixel_y;
    assign visible      = ores_reg.visible;
    assign nmi_pulse    = ores_reg.nmi_pulse;
    assign frame_done   = ores_reg.frame_done;
    assign rendering_on = ores_reg.rendering_on;

    // no item taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("item accepted during memory clear");

    // a result is only raised at the end of phase 2
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == ST_PH2))
        else $error("result raised outside phase 2");

    // an accepted item always enters phase 1
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_PH1))
        else $error("accepted item did not start");

    // dot counter stays within the line
    assert property (@(posedge clk) disable iff (!rst_n)
        dot_reg < 9'(DOTS_PER_LINE))
        else $error("dot counter out of range");

endmodule
